// ----- hdl/nmsu_pkg.sv -----
// ----------------------------------------------------------------------------
// nmsu_pkg
// Shared constants and types of the non-maximum suppression unit.
// ----------------------------------------------------------------------------
package nmsu_pkg;

	localparam int SCORE_W         = 16;
	localparam int THR_W           = 16;
	localparam int WEIGHT_W        = 16;
	localparam int NUM_FIELDS      = 5;
	localparam int FLD_W           = 3;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = 16;

	localparam int MAX_BOXES_DEF   = 64;
	localparam int COORD_WIDTH_DEF = 12;
	localparam int EXP_DEPTH_DEF   = 256;

	localparam logic [CFG_IDX_W-1:0] REG_OVL_THR  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NMS_MODE = 4'd1;

	localparam logic [THR_W-1:0] THR_RESET  = 16'd19661;
	localparam logic             MODE_HARD  = 1'b0;
	localparam logic             MODE_BLEND = 1'b1;

	// status of the result offered by the sequencer
	typedef struct packed {
		logic valid;
		logic last;
		logic overflow;
	} res_ctl_t;

endpackage

// ----- hdl/non_maximum_suppression_unit.sv -----
// ----------------------------------------------------------------------------
// non_maximum_suppression_unit
// Greedy IoU non-maximum suppression with hard and score-blended modes.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  in       | in_valid / in_stall | box_x1 box_y1 box_x2 box_y2 box_score last
//  out      | out_valid/out_stall | out_x1..out_y2 out_score overflow last
//  cfg      | cfg_valid/cfg_ready | cfg_index cfg_data
//
//  boxes load one per cycle; after the last box input stalls until the
//  final result transfer. a group is a head search, a head fetch, a test of
//  each candidate plus inner area, area and compare on the shared multiplier
//  for each overlapping one, and the result handover; blending adds a weight
//  and a multiply-add per field for each member and 5 divides. reset empties
//  the frame; a stall on a full output holds the sequencer at its result.
// ----------------------------------------------------------------------------
module non_maximum_suppression_unit import nmsu_pkg::*; #(
	parameter int MAX_BOXES       = MAX_BOXES_DEF,
	parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
	parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [COORD_WIDTH-1:0] box_x1,
	input  logic [COORD_WIDTH-1:0] box_y1,
	input  logic [COORD_WIDTH-1:0] box_x2,
	input  logic [COORD_WIDTH-1:0] box_y2,
	input  logic [SCORE_W-1:0]     box_score,
	input  logic                   box_last,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [COORD_WIDTH-1:0] out_x1,
	output logic [COORD_WIDTH-1:0] out_y1,
	output logic [COORD_WIDTH-1:0] out_x2,
	output logic [COORD_WIDTH-1:0] out_y2,
	output logic [SCORE_W-1:0]     out_score,
	output logic                   out_overflow,
	output logic                   out_last,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [THR_W-1:0]       thr_q;
	logic                   mode_q;
	logic                   load_ready;
	logic                   in_xfer;
	logic                   res_take;
	res_ctl_t               res_ctl;
	logic [COORD_WIDTH-1:0] res_x1, res_y1, res_x2, res_y2;
	logic [SCORE_W-1:0]     res_score;
	logic                   out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = !load_ready;
	assign in_xfer   = in_valid && load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			mode_q <= MODE_HARD;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OVL_THR:  thr_q  <= cfg_data[THR_W-1:0];
				REG_NMS_MODE: mode_q <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	nmsu_seq #(
		.MAX_BOXES      (MAX_BOXES),
		.COORD_WIDTH    (COORD_WIDTH),
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_xfer      (in_xfer),
		.box_x1       (box_x1),
		.box_y1       (box_y1),
		.box_x2       (box_x2),
		.box_y2       (box_y2),
		.box_score    (box_score),
		.box_last     (box_last),
		.load_ready   (load_ready),
		.ovl_thr      (thr_q),
		.nms_mode     (mode_q),
		.res_ctl      (res_ctl),
		.res_x1       (res_x1),
		.res_y1       (res_y1),
		.res_x2       (res_x2),
		.res_y2       (res_y2),
		.res_score    (res_score),
		.res_take     (res_take)
	);

	// output register frees the sequencer once the result is copied
	assign res_take = res_ctl.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_x1       <= res_x1;
			out_y1       <= res_y1;
			out_x2       <= res_x2;
			out_y2       <= res_y2;
			out_score    <= res_score;
			out_overflow <= res_ctl.overflow;
			out_last     <= res_ctl.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hdl/nmsu_div.sv -----
// ----------------------------------------------------------------------------
// nmsu_div
// Restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module nmsu_div #(
	parameter int NW = 40,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic          fits;

	assign shifted = {rem_q[DW-1:0], quo_q[NW-1]};
	assign fits    = shifted >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, den}) : shifted;
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- hdl/nmsu_seq.sv -----
// ----------------------------------------------------------------------------
// nmsu_seq
// Box store, merge flags and the sequencer for head search, for overlap tests
// and weighting on one shared multiplier, and for the divider.
// ----------------------------------------------------------------------------
module nmsu_seq import nmsu_pkg::*; #(
	parameter int MAX_BOXES       = MAX_BOXES_DEF,
	parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
	parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_xfer,
	input  logic [COORD_WIDTH-1:0] box_x1,
	input  logic [COORD_WIDTH-1:0] box_y1,
	input  logic [COORD_WIDTH-1:0] box_x2,
	input  logic [COORD_WIDTH-1:0] box_y2,
	input  logic [SCORE_W-1:0]     box_score,
	input  logic                   box_last,
	output logic                   load_ready,
	input  logic [THR_W-1:0]       ovl_thr,
	input  logic                   nms_mode,
	output res_ctl_t               res_ctl,
	output logic [COORD_WIDTH-1:0] res_x1,
	output logic [COORD_WIDTH-1:0] res_y1,
	output logic [COORD_WIDTH-1:0] res_x2,
	output logic [COORD_WIDTH-1:0] res_y2,
	output logic [SCORE_W-1:0]     res_score,
	input  logic                   res_take
);

	localparam int CW    = COORD_WIDTH;
	localparam int IW    = $clog2(MAX_BOXES);
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int SW    = CW + 1;
	localparam int MB    = (CW + 1 > SCORE_W) ? CW + 1 : SCORE_W;
	localparam int MA    = 2 * CW + 3;
	localparam int PW    = MA + MB;
	localparam int KW    = $clog2(EXP_TABLE_DEPTH);
	localparam int TOT_W = WEIGHT_W + IW + 1;
	localparam int ACC_W = WEIGHT_W + SCORE_W + IW + 1;
	localparam int EW    = 4 * CW + SCORE_W;

	typedef enum logic [3:0] {
		S_LOAD, S_FRD, S_FEV, S_HRD, S_HLD, S_HAREA, S_CRD, S_CEV,
		S_INNER, S_AREA, S_CMP, S_WT, S_ACC, S_DIV, S_DWAIT, S_OUT
	} state_t;

	// exp(k / depth) in Q2.14, truncated Taylor series in Q2.30
	function automatic logic [WEIGHT_W-1:0] exp_entry(input int unsigned idx);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		x    = (64'(idx) << 30) / EXP_TABLE_DEPTH;
		term = 64'd1 << 30;
		sum  = term;
		for (int n = 1; n <= 24; n++) begin
			term = ((term * x) >> 30) / 64'(n);
			sum  = sum + term;
		end
		return WEIGHT_W'((sum + (64'd1 << 15)) >> 16);
	endfunction

	logic [WEIGHT_W-1:0] exp_lut [EXP_TABLE_DEPTH];
	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_lut
		assign exp_lut[g] = exp_entry(g);
	end

	state_t               state_q;
	logic [EW-1:0]        mem [MAX_BOXES];
	logic [EW-1:0]        rd_q;
	logic [IW-1:0]        rd_addr;
	logic [CNT_W-1:0]     cnt_q;
	logic                 ovf_q;
	logic [MAX_BOXES-1:0] merged_q;
	logic [MAX_BOXES-1:0] vmask;
	logic [IW-1:0]        idx_q;
	logic [IW-1:0]        best_q;
	logic [SCORE_W-1:0]   best_score_q;
	logic                 found_q;
	logic                 acc_head_q;
	logic [FLD_W-1:0]     fld_q;
	logic [SCORE_W-1:0]   h_f [NUM_FIELDS];
	logic [SCORE_W-1:0]   m_f [NUM_FIELDS];
	logic [SCORE_W-1:0]   res_q [NUM_FIELDS];
	logic [ACC_W-1:0]     acc_q [NUM_FIELDS];
	logic [TOT_W-1:0]     tot_q;
	logic [WEIGHT_W-1:0]  w_q;
	logic [SW-1:0]        span_x_q;
	logic [SW-1:0]        span_y_q;
	logic [SW-1:0]        iw_q;
	logic [SW-1:0]        ih_q;
	logic [2*SW-1:0]      ha0_q;
	logic [2*SW-1:0]      a1_q;
	logic [2*SW-1:0]      inner_q;

	logic [CW-1:0]        rd_x1, rd_y1, rd_x2, rd_y2;
	logic [SCORE_W-1:0]   rd_score;
	logic [CW-1:0]        ix0, iy0, ix1, iy1;
	logic signed [CW+1:0] iw, ih;
	logic                 overlap;
	logic [SW-1:0]        rd_span_x, rd_span_y;
	logic [MA-1:0]        mul_a, uni;
	logic [MB-1:0]        mul_b;
	logic [PW-1:0]        prod;
	logic                 joins;
	logic                 at_end;
	logic                 remaining;
	logic [KW+SCORE_W-1:0] kprod;
	logic [KW-1:0]        kidx;
	logic                 div_start, div_busy, div_done;
	logic [ACC_W-1:0]     div_quo;

	assign rd_x1    = rd_q[EW-1 -: CW];
	assign rd_y1    = rd_q[EW-1-CW -: CW];
	assign rd_x2    = rd_q[2*CW+SCORE_W-1 -: CW];
	assign rd_y2    = rd_q[CW+SCORE_W-1 -: CW];
	assign rd_score = rd_q[SCORE_W-1:0];

	assign rd_addr = (state_q == S_HRD) ? best_q : idx_q;

	always_ff @(posedge clk) begin
		if (in_xfer && cnt_q < CNT_W'(MAX_BOXES)) begin
			mem[cnt_q[IW-1:0]] <= {box_x1, box_y1, box_x2, box_y2, box_score};
		end
		rd_q <= mem[rd_addr];
	end

	// overlap of the head with the candidate just read
	assign ix0 = (h_f[0][CW-1:0] > rd_x1) ? h_f[0][CW-1:0] : rd_x1;
	assign iy0 = (h_f[1][CW-1:0] > rd_y1) ? h_f[1][CW-1:0] : rd_y1;
	assign ix1 = (h_f[2][CW-1:0] < rd_x2) ? h_f[2][CW-1:0] : rd_x2;
	assign iy1 = (h_f[3][CW-1:0] < rd_y2) ? h_f[3][CW-1:0] : rd_y2;
	assign iw  = $signed({2'b00, ix1}) - $signed({2'b00, ix0}) + $signed((CW + 2)'(1));
	assign ih  = $signed({2'b00, iy1}) - $signed({2'b00, iy0}) + $signed((CW + 2)'(1));
	assign overlap = !iw[CW+1] && (iw != '0) && !ih[CW+1] && (ih != '0);

	assign rd_span_x = SW'(rd_x2) - SW'(rd_x1) + SW'(1);
	assign rd_span_y = SW'(rd_y2) - SW'(rd_y1) + SW'(1);

	assign uni = MA'(ha0_q) + MA'(a1_q) - MA'(inner_q);

	// the one shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_HAREA, S_AREA: begin
				mul_a = MA'(span_x_q);
				mul_b = MB'(span_y_q);
			end
			S_INNER: begin
				mul_a = MA'(iw_q);
				mul_b = MB'(ih_q);
			end
			S_CMP: begin
				mul_a = uni;
				mul_b = MB'(ovl_thr);
			end
			S_ACC: begin
				mul_a = MA'(m_f[fld_q]);
				mul_b = MB'(w_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod  = PW'(mul_a) * PW'(mul_b);
	assign joins = PW'({inner_q, 16'h0000}) > prod;

	assign kprod = (KW + SCORE_W)'(m_f[4]) * (KW + SCORE_W)'(EXP_TABLE_DEPTH);
	assign kidx  = kprod[SCORE_W +: KW];

	assign at_end = CNT_W'(idx_q) == cnt_q - CNT_W'(1);

	always_comb begin
		for (int i = 0; i < MAX_BOXES; i++) begin
			vmask[i] = CNT_W'(i) < cnt_q;
		end
	end
	assign remaining = |(~merged_q & vmask);

	assign div_start = (state_q == S_DIV) && !div_busy;

	nmsu_div #(
		.NW(ACC_W),
		.DW(TOT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (acc_q[fld_q]),
		.den   (tot_q),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
			merged_q     <= '0;
			idx_q        <= '0;
			best_q       <= '0;
			best_score_q <= '0;
			found_q      <= 1'b0;
			acc_head_q   <= 1'b0;
			fld_q        <= '0;
			tot_q        <= '0;
			w_q          <= '0;
			span_x_q     <= '0;
			span_y_q     <= '0;
			iw_q         <= '0;
			ih_q         <= '0;
			ha0_q        <= '0;
			a1_q         <= '0;
			inner_q      <= '0;
			for (int f = 0; f < NUM_FIELDS; f++) begin
				h_f[f]   <= '0;
				m_f[f]   <= '0;
				res_q[f] <= '0;
				acc_q[f] <= '0;
			end
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						if (cnt_q < CNT_W'(MAX_BOXES)) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (box_last) begin
							idx_q   <= '0;
							found_q <= 1'b0;
							state_q <= S_FRD;
						end
					end
				end
				S_FRD: state_q <= S_FEV;
				S_FEV: begin
					// strict compare keeps the earliest box on equal scores
					if (!merged_q[idx_q] && (!found_q || rd_score > best_score_q)) begin
						found_q      <= 1'b1;
						best_q       <= idx_q;
						best_score_q <= rd_score;
					end
					if (at_end) begin
						state_q <= S_HRD;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_FRD;
					end
				end
				S_HRD: state_q <= S_HLD;
				S_HLD: begin
					h_f[0] <= SCORE_W'(rd_x1);
					h_f[1] <= SCORE_W'(rd_y1);
					h_f[2] <= SCORE_W'(rd_x2);
					h_f[3] <= SCORE_W'(rd_y2);
					h_f[4] <= rd_score;
					m_f[0] <= SCORE_W'(rd_x1);
					m_f[1] <= SCORE_W'(rd_y1);
					m_f[2] <= SCORE_W'(rd_x2);
					m_f[3] <= SCORE_W'(rd_y2);
					m_f[4] <= rd_score;
					span_x_q <= rd_span_x;
					span_y_q <= rd_span_y;
					merged_q[best_q] <= 1'b1;
					for (int f = 0; f < NUM_FIELDS; f++) begin
						acc_q[f] <= '0;
					end
					tot_q   <= '0;
					state_q <= S_HAREA;
				end
				S_HAREA: begin
					ha0_q <= prod[2*SW-1:0];
					idx_q <= '0;
					if (nms_mode == MODE_BLEND) begin
						acc_head_q <= 1'b1;
						state_q    <= S_WT;
					end else begin
						state_q <= S_CRD;
					end
				end
				S_CRD: state_q <= S_CEV;
				S_CEV: begin
					m_f[0]   <= SCORE_W'(rd_x1);
					m_f[1]   <= SCORE_W'(rd_y1);
					m_f[2]   <= SCORE_W'(rd_x2);
					m_f[3]   <= SCORE_W'(rd_y2);
					m_f[4]   <= rd_score;
					span_x_q <= rd_span_x;
					span_y_q <= rd_span_y;
					iw_q     <= iw[SW-1:0];
					ih_q     <= ih[SW-1:0];
					if (!merged_q[idx_q] && overlap) begin
						state_q <= S_INNER;
					end else if (at_end) begin
						fld_q   <= '0;
						state_q <= (nms_mode == MODE_BLEND) ? S_DIV : S_OUT;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_CRD;
					end
				end
				S_INNER: begin
					inner_q <= prod[2*SW-1:0];
					state_q <= S_AREA;
				end
				S_AREA: begin
					a1_q    <= prod[2*SW-1:0];
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (joins) begin
						merged_q[idx_q] <= 1'b1;
					end
					if (joins && nms_mode == MODE_BLEND) begin
						acc_head_q <= 1'b0;
						state_q    <= S_WT;
					end else if (at_end) begin
						fld_q   <= '0;
						state_q <= (nms_mode == MODE_BLEND) ? S_DIV : S_OUT;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_CRD;
					end
				end
				S_WT: begin
					w_q     <= exp_lut[kidx];
					tot_q   <= tot_q + TOT_W'(exp_lut[kidx]);
					fld_q   <= '0;
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q[fld_q] <= acc_q[fld_q] + ACC_W'(prod);
					if (fld_q == FLD_W'(NUM_FIELDS - 1)) begin
						fld_q <= '0;
						if (acc_head_q) begin
							state_q <= S_CRD;
						end else if (at_end) begin
							state_q <= S_DIV;
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= S_CRD;
						end
					end else begin
						fld_q <= fld_q + FLD_W'(1);
					end
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_done) begin
						res_q[fld_q] <= SCORE_W'(div_quo);
						if (fld_q == FLD_W'(NUM_FIELDS - 1)) begin
							state_q <= S_OUT;
						end else begin
							fld_q   <= fld_q + FLD_W'(1);
							state_q <= S_DIV;
						end
					end
				end
				S_OUT: begin
					if (res_take) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						if (!remaining) begin
							cnt_q    <= '0;
							ovf_q    <= 1'b0;
							merged_q <= '0;
							state_q  <= S_LOAD;
						end else begin
							state_q <= S_FRD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign load_ready       = state_q == S_LOAD;
	assign res_ctl.valid    = state_q == S_OUT;
	assign res_ctl.last     = !remaining;
	assign res_ctl.overflow = ovf_q;

	// hard mode hands the head straight through
	assign res_x1    = (nms_mode == MODE_BLEND) ? res_q[0][CW-1:0] : h_f[0][CW-1:0];
	assign res_y1    = (nms_mode == MODE_BLEND) ? res_q[1][CW-1:0] : h_f[1][CW-1:0];
	assign res_x2    = (nms_mode == MODE_BLEND) ? res_q[2][CW-1:0] : h_f[2][CW-1:0];
	assign res_y2    = (nms_mode == MODE_BLEND) ? res_q[3][CW-1:0] : h_f[3][CW-1:0];
	assign res_score = (nms_mode == MODE_BLEND) ? res_q[4] : h_f[4];

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_BOXES))
		else $error("box count above capacity");

	a_merged_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(merged_q & ~vmask) == '0)
		else $error("merge flag set past the stored boxes");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res_take && res_ctl.valid && res_ctl.last) |=> (cnt_q == '0 && merged_q == '0))
		else $error("frame state not cleared after final result");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DWAIT)
		else $error("divider finished outside its wait state");

endmodule
